### rtl/clsr_pkg.sv
// Package for the combined LCG shuffle generator: widths, generator constants,
// reciprocal constants for the constant divisions, and controller/datapath command type.
// No dependencies.
package clsr_pkg;

  localparam int ValW = 31;
  localparam int KW = 16;
  localparam int TableDepthDef = 32;

  // Generator constants (Schrage form: m = a*q + r)
  localparam logic [ValW-1:0] ModA = 31'd2147483563;
  localparam logic [ValW-1:0] ModB = 31'd2147483399;
  localparam logic [ValW-1:0] ModAm1 = 31'd2147483562;
  localparam logic [KW-1:0] MulA = 16'd40014;
  localparam logic [KW-1:0] MulB = 16'd40692;
  localparam logic [KW-1:0] QuoA = 16'd53668;
  localparam logic [KW-1:0] QuoB = 16'd52774;
  localparam logic [KW-1:0] RemA = 16'd12211;
  localparam logic [KW-1:0] RemB = 16'd3791;
  localparam logic [ValW-1:0] SecondReset = 31'd123456789;
  localparam logic [23:0] FracCap = 24'd16777213;

  // floor(x / q) = (x * Rcp) >> RcpShift, exact for every 31-bit x
  localparam int RcpShiftA = ValW + $clog2(QuoA);
  localparam int RcpShiftB = ValW + $clog2(QuoB);
  localparam logic [31:0] RcpA =
    32'(((64'd1 << RcpShiftA) + 64'(QuoA) - 64'd1) / 64'(QuoA));
  localparam logic [31:0] RcpB =
    32'(((64'd1 << RcpShiftB) + 64'(QuoB) - 64'd1) / 64'(QuoB));

  // Division by ModA: 2^31 = ModA + ModAGap, so each step folds the bits above
  // bit 30 back in; three steps bring any 62-bit dividend below 2^31
  localparam logic [6:0] ModAGap = 7'd85;
  localparam int DivSteps = 3;
  localparam int DivCntW = $clog2(DivSteps);

  localparam logic OpReseed = 1'b0;
  localparam logic OpDraw = 1'b1;

  typedef struct packed {
    logic load_seed;
    logic load_range;
    logic seed_step;
    logic seed_wr;
    logic seed_last;
    logic draw_step;
    logic draw_mix;
    logic mul;
    logic div_init;
    logic div_run;
    logic out_load;
  } dp_cmd_t;

endpackage

### rtl/clsr_schrage.sv
// Two-stage Schrage multiply-mod unit, running both generators side by side.
// Inputs are registered in stage 1 and stage 2; the result is combinational from stage 2. Depends on clsr_pkg.
module clsr_schrage import clsr_pkg::*; (
  input  logic            clk_i,
  input  logic [ValW-1:0] xa_i,
  input  logic [ValW-1:0] xb_i,
  output logic [ValW-1:0] ya_o,
  output logic [ValW-1:0] yb_o
);

  logic [ValW-1:0] xa1_q, xb1_q, xa2_q, xb2_q;
  logic [62:0]     pa_q, pb_q;
  logic [KW-1:0]   ka, kb;
  logic [31:0]     kqa_q, kqb_q, kra_q, krb_q;
  logic [KW-1:0]   rema, remb;
  logic [31:0]     ara, arb;
  logic [32:0]     va, vb, wa, wb;

  // Stage 1: reciprocal multiply for floor(x / q)
  always_ff @(posedge clk_i) begin
    xa1_q <= xa_i;
    xb1_q <= xb_i;
    pa_q  <= 63'(xa_i) * 63'(RcpA);
    pb_q  <= 63'(xb_i) * 63'(RcpB);
  end

  assign ka = pa_q[RcpShiftA +: KW];
  assign kb = pb_q[RcpShiftB +: KW];

  // Stage 2: k*q and k*r
  always_ff @(posedge clk_i) begin
    xa2_q <= xa1_q;
    xb2_q <= xb1_q;
    kqa_q <= 32'(ka) * 32'(QuoA);
    kqb_q <= 32'(kb) * 32'(QuoB);
    kra_q <= 32'(ka) * 32'(RemA);
    krb_q <= 32'(kb) * 32'(RemB);
  end

  // a*(x mod q) - k*r, fold back by m when negative
  always_comb begin
    rema = KW'(xa2_q - kqa_q[ValW-1:0]);
    remb = KW'(xb2_q - kqb_q[ValW-1:0]);
    ara  = 32'(rema) * 32'(MulA);
    arb  = 32'(remb) * 32'(MulB);
    va   = {1'b0, ara} - {1'b0, kra_q};
    vb   = {1'b0, arb} - {1'b0, krb_q};
    wa   = va[32] ? (va + {2'b00, ModA}) : va;
    wb   = vb[32] ? (vb + {2'b00, ModB}) : vb;
    ya_o = wa[ValW-1:0];
    yb_o = wb[ValW-1:0];
  end

endmodule

### rtl/clsr_dp.sv
// Datapath: generator state, shuffle table memory, index reciprocal, scaling
// multiplier and the two-lane division by the first modulus. Depends on clsr_pkg and clsr_schrage.
module clsr_dp import clsr_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dp_cmd_t                        cmd_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] seed_addr_i,
  input  logic signed [31:0]             seed_i,
  input  logic [ValW-1:0]                range_limit_i,
  output logic                           div_done_o,
  output logic [ValW-1:0]                raw_value_o,
  output logic [23:0]                    fraction_o,
  output logic [ValW-1:0]                scaled_int_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [63:0] Bucket = 64'd1 + (64'(ModA) - 64'd2) / 64'(TABLE_DEPTH);
  localparam int BktShift = ValW + $clog2(Bucket);
  localparam logic [31:0] BktRcp =
    32'(((64'd1 << BktShift) + Bucket - 64'd1) / Bucket);

  logic [ValW-1:0] first_q, first_d, second_q, second_d, last_q, last_d;
  logic [ValW-1:0] ya, yb;
  logic [ValW-1:0] range_q;

  logic [ValW-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q, vld_d;
  logic [ValW-1:0] rd_q, tbl_val;
  logic            rd_vld_q;
  logic [62:0]     bprod_q, bquot;
  logic [AW-1:0]   idx;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [ValW-1:0] wr_data;

  logic [31:0]     neg;
  logic [ValW-1:0] mag_abs, mag;
  logic [32:0]     mix, mixed;

  logic [61:0]     mul_q;
  logic [61:0]     rs_q, rf_q, rs_fold, rf_fold;
  logic [ValW-1:0] qs_q, qf_q, qs_fin, qf_fin;
  logic [DivCntW-1:0] div_cnt_q;
  logic [23:0]     frac_raw;

  clsr_schrage u_schrage (
    .clk_i (clk_i),
    .xa_i  (first_q),
    .xb_i  (second_q),
    .ya_o  (ya),
    .yb_o  (yb)
  );

  // Seed magnitude: most negative saturates, zero becomes one
  always_comb begin
    neg     = 32'(-seed_i);
    mag_abs = seed_i[31] ? (neg[31] ? {ValW{1'b1}} : neg[ValW-1:0]) : seed_i[ValW-1:0];
    mag     = (mag_abs == '0) ? ValW'(1) : mag_abs;
  end

  // Table index = last / bucket, saturated
  always_comb begin
    bquot = bprod_q >> BktShift;
    if (bquot > 63'(TABLE_DEPTH - 1)) begin
      idx = AW'(TABLE_DEPTH - 1);
    end else begin
      idx = bquot[AW-1:0];
    end
  end

  assign tbl_val = rd_vld_q ? rd_q : '0;

  always_comb begin
    mix   = {2'b00, tbl_val} - {2'b00, second_q};
    mixed = (mix[32] || mix == '0) ? (mix + {2'b00, ModAm1}) : mix;
  end

  always_comb begin
    wr_en   = (cmd_i.seed_step && cmd_i.seed_wr) || cmd_i.draw_mix;
    wr_addr = cmd_i.draw_mix ? idx : seed_addr_i;
    wr_data = cmd_i.draw_mix ? first_q : ya;
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    last_d   = last_q;
    vld_d    = vld_q;
    if (cmd_i.load_seed) begin
      first_d  = mag;
      second_d = mag;
    end
    if (cmd_i.seed_step) begin
      first_d = ya;
      if (cmd_i.seed_last) begin
        last_d = ya;
      end
    end
    if (cmd_i.draw_step) begin
      first_d  = ya;
      second_d = yb;
    end
    if (cmd_i.draw_mix) begin
      last_d = mixed[ValW-1:0];
    end
    if (wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      second_q  <= SecondReset;
      last_q    <= '0;
      vld_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      last_q   <= last_d;
      vld_q    <= vld_d;
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_run) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
    end
  end

  // Shuffle table memory, registered read at the current index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[idx];
    rd_vld_q <= vld_q[idx];
    bprod_q  <= 63'(last_q) * 63'(BktRcp);
  end

  // Fold the part above bit 30 back in as hi * ModAGap, counting hi into the
  // quotient; one final compare against ModA, adding one to the quotient, finishes the division
  always_comb begin
    rs_fold = 62'(rs_q[ValW-1:0]) + 62'(rs_q[61:ValW]) * 62'(ModAGap);
    rf_fold = 62'(rf_q[ValW-1:0]) + 62'(rf_q[61:ValW]) * 62'(ModAGap);
    qs_fin  = qs_q + ValW'(rs_q >= 62'(ModA));
    qf_fin  = qf_q + ValW'(rf_q >= 62'(ModA));
  end

  assign div_done_o = cmd_i.div_run && (div_cnt_q == DivCntW'(DivSteps - 1));
  assign frac_raw = qf_fin[23:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_range) begin
      range_q <= range_limit_i;
    end
    if (cmd_i.mul) begin
      mul_q <= 62'(last_q) * 62'(range_q);
    end
    if (cmd_i.div_init) begin
      rs_q <= mul_q;
      rf_q <= {7'd0, last_q, 24'd0};
      qs_q <= '0;
      qf_q <= '0;
    end else if (cmd_i.div_run) begin
      rs_q <= rs_fold;
      rf_q <= rf_fold;
      qs_q <= qs_q + rs_q[61:ValW];
      qf_q <= qf_q + rf_q[61:ValW];
    end
    if (cmd_i.out_load) begin
      raw_value_o <= last_q;
      fraction_o  <= (frac_raw > FracCap) ? FracCap : frac_raw;
      if (range_q == '0) begin
        scaled_int_o <= '0;
      end else if (qs_fin > range_q - ValW'(1)) begin
        scaled_int_o <= range_q - ValW'(1);
      end else begin
        scaled_int_o <= qs_fin;
      end
    end
  end

endmodule

### rtl/clsr_ctrl.sv
// Controller: sequences reseed warm-up, draw steps, division and output transfer.
// Depends on clsr_pkg.
module clsr_ctrl import clsr_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic                           div_done_i,
  output dp_cmd_t                        cmd_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] seed_addr_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 8);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRsGen = 3'd1;
  localparam logic [2:0] StDrGen = 3'd2;
  localparam logic [2:0] StDrMix = 3'd3;
  localparam logic [2:0] StDrMul = 3'd4;
  localparam logic [2:0] StDrIni = 3'd5;
  localparam logic [2:0] StDrDiv = 3'd6;
  localparam logic [2:0] StDrOut = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [1:0]    wcnt_q, wcnt_d;
  logic [CW-1:0] step_q, step_d;
  logic          out_valid_q, out_valid_d;
  logic          accept;
  logic          gen_ready;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign gen_ready   = (wcnt_q == 2'd2);
  assign out_valid_o = out_valid_q;
  assign seed_addr_o = step_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    wcnt_d  = wcnt_q + 2'd1;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        wcnt_d = '0;
        if (accept) begin
          if (op_i == OpReseed) begin
            cmd_o.load_seed = 1'b1;
            step_d  = CW'(TABLE_DEPTH + 7);
            state_d = StRsGen;
          end else begin
            cmd_o.load_range = 1'b1;
            state_d = StDrGen;
          end
        end
      end
      StRsGen: begin
        // wait out the unit latency, then advance the first generator
        if (gen_ready) begin
          cmd_o.seed_step = 1'b1;
          cmd_o.seed_wr   = (step_q < CW'(TABLE_DEPTH));
          cmd_o.seed_last = (step_q == '0);
          wcnt_d = '0;
          if (step_q == '0) begin
            state_d = StIdle;
          end else begin
            step_d = step_q - CW'(1);
          end
        end
      end
      StDrGen: begin
        if (gen_ready) begin
          cmd_o.draw_step = 1'b1;
          state_d = StDrMix;
        end
      end
      StDrMix: begin
        cmd_o.draw_mix = 1'b1;
        state_d = StDrMul;
      end
      StDrMul: begin
        cmd_o.mul = 1'b1;
        state_d = StDrIni;
      end
      StDrIni: begin
        cmd_o.div_init = 1'b1;
        state_d = StDrDiv;
      end
      StDrDiv: begin
        cmd_o.div_run = 1'b1;
        if (div_done_i) begin
          state_d = StDrOut;
        end
      end
      StDrOut: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wcnt_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/combined_lcg_shuffle_rng_top.sv
// Top level of the combined LCG generator with shuffle table.
// Depends on clsr_pkg, clsr_ctrl, clsr_dp.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o | op_i, seed_i, range_limit_i
//   out     | out_valid_o/out_ready_i | raw_value_o, fraction_o, scaled_int_o
//
// A draw passes from transfer to result through the wait on the Schrage unit,
// the mix of the table entry, the multiply, the set-up, three division folds
// and the load of the output register. A reseed steps the first generator
// TABLE_DEPTH + 8 times, writing the table on the last TABLE_DEPTH steps.
// Reset loads the reset generator state and marks every table entry invalid, so it reads as zero.
// A new item is taken while a result waits; a draw stalls only at its end.
module combined_lcg_shuffle_rng_top import clsr_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic signed [31:0]     seed_i,
  input  logic [ValW-1:0]        range_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ValW-1:0]        raw_value_o,
  output logic [23:0]            fraction_o,
  output logic [ValW-1:0]        scaled_int_o
);

  dp_cmd_t                        cmd;
  logic [$clog2(TABLE_DEPTH)-1:0] seed_addr;
  logic                           div_done;

  clsr_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .div_done_i  (div_done),
    .cmd_o       (cmd),
    .seed_addr_o (seed_addr)
  );

  clsr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .seed_addr_i   (seed_addr),
    .seed_i        (seed_i),
    .range_limit_i (range_limit_i),
    .div_done_o    (div_done),
    .raw_value_o   (raw_value_o),
    .fraction_o    (fraction_o),
    .scaled_int_o  (scaled_int_o)
  );

endmodule
